### rtl/qmci_pkg.sv
// Package with widths, register codes, stage controls and helpers of the Morton cell index block.
package qmci_pkg;

   localparam int MAX_LEVEL = 8;
   localparam int LEVEL_W   = 4;
   localparam int FIX_W     = 32;
   localparam int COORD_W   = MAX_LEVEL;
   localparam int MORTON_W  = 2 * MAX_LEVEL;
   localparam int SUM_W     = 2 * MAX_LEVEL + 2;
   localparam int INDEX_W   = 17;
   localparam int DEPTH_W   = 4;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TREE_LEVEL      = 3'd0,
      CSR_REGION_LEFT     = 3'd1,
      CSR_REGION_TOP      = 3'd2,
      CSR_INV_CELL_WIDTH  = 3'd3,
      CSR_INV_CELL_HEIGHT = 3'd4
   } qmci_csr_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } qmci_load_type;

   function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] lvl);
      logic [LEVEL_W-1:0] r;
      r = lvl;
      if (lvl > LEVEL_W'(MAX_LEVEL)) begin
         r = LEVEL_W'(MAX_LEVEL);
      end
      return r;
   endfunction

   // Number of cells above depth d, that is (4^d - 1) / 3.
   function automatic logic [SUM_W-1:0] level_offset(input logic [LEVEL_W:0] d);
      logic [SUM_W-1:0] r;
      r = '0;
      for (int i = 0; i <= MAX_LEVEL; i++) begin
         if (i < int'(d)) begin
            r[2*i] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [MORTON_W-1:0] interleave(input logic [COORD_W-1:0] x,
                                                      input logic [COORD_W-1:0] y);
      logic [MORTON_W-1:0] r;
      r = '0;
      for (int i = 0; i < COORD_W; i++) begin
         r[2*i]   = x[i];
         r[2*i+1] = y[i];
      end
      return r;
   endfunction

endpackage

### rtl/qmci_corner.sv
// Origin subtract and reciprocal multiply of one box corner coordinate.
module qmci_corner (
   input  logic                             clock,
   input  qmci_pkg::qmci_load_type          load,
   input  logic signed [qmci_pkg::FIX_W-1:0] pos,
   input  logic signed [qmci_pkg::FIX_W-1:0] origin,
   input  logic        [qmci_pkg::FIX_W-1:0] inv,
   output logic        [qmci_pkg::FIX_W-1:0] grid,
   output logic                             neg
);
   import qmci_pkg::*;

   logic [FIX_W:0]     diff_ff;
   logic [FIX_W:0]     diff_in;
   logic [2*FIX_W-1:0] product;
   logic [FIX_W-1:0]   grid_ff;
   logic               neg_ff;

   assign diff_in = {pos[FIX_W-1], pos} - {origin[FIX_W-1], origin};
   assign product = diff_ff[FIX_W-1:0] * inv;

   always_ff @(posedge clock) begin
      if (load.s1) begin
         diff_ff <= diff_in;
      end
      if (load.s2) begin
         grid_ff <= product[2*FIX_W-1:FIX_W];
         neg_ff  <= diff_ff[FIX_W];
      end
   end

   assign grid = grid_ff;
   assign neg  = neg_ff;

endmodule

### rtl/qmci_encode.sv
// Grid range check, Morton interleave and common level search of the two corners.
module qmci_encode (
   input  logic                              clock,
   input  qmci_pkg::qmci_load_type           load,
   input  logic [qmci_pkg::LEVEL_W-1:0]      level,
   input  logic [qmci_pkg::FIX_W-1:0]        left_grid,
   input  logic [qmci_pkg::FIX_W-1:0]        top_grid,
   input  logic [qmci_pkg::FIX_W-1:0]        right_grid,
   input  logic [qmci_pkg::FIX_W-1:0]        bottom_grid,
   input  logic [3:0]                        neg,
   output logic [qmci_pkg::MORTON_W-1:0]     space,
   output logic [qmci_pkg::LEVEL_W-1:0]      depth,
   output logic                              ok
);
   import qmci_pkg::*;

   logic [MORTON_W-1:0] lt_ff;
   logic [MORTON_W-1:0] rb_ff;
   logic                ok3_ff;
   logic                ok3_in;
   logic [MORTON_W-1:0] space_ff;
   logic [MORTON_W-1:0] space_in;
   logic [LEVEL_W-1:0]  depth_ff;
   logic [LEVEL_W-1:0]  depth_in;
   logic                ok4_ff;
   logic [MORTON_W-1:0] dif;
   logic [LEVEL_W-1:0]  hi;

   assign ok3_in = (neg == 4'b0000)
                && ((left_grid >> level) == '0) && ((top_grid >> level) == '0)
                && ((right_grid >> level) == '0) && ((bottom_grid >> level) == '0);

   assign dif = lt_ff ^ rb_ff;

   always_comb begin
      hi = '0;
      for (int i = 0; i < MAX_LEVEL; i++) begin
         if ((i < int'(level)) && (dif[2*i +: 2] != 2'b00)) begin
            hi = LEVEL_W'(i + 1);
         end
      end
      depth_in = level - hi;
      space_in = rb_ff >> {hi, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (load.s3) begin
         lt_ff  <= interleave(left_grid[COORD_W-1:0], top_grid[COORD_W-1:0]);
         rb_ff  <= interleave(right_grid[COORD_W-1:0], bottom_grid[COORD_W-1:0]);
         ok3_ff <= ok3_in;
      end
      if (load.s4) begin
         space_ff <= space_in;
         depth_ff <= depth_in;
         ok4_ff   <= ok3_ff;
      end
   end

   assign space = space_ff;
   assign depth = depth_ff;
   assign ok    = ok4_ff;

endmodule

### rtl/qmci_index.sv
// Linear cell index offset, cell count check and result register.
module qmci_index (
   input  logic                            clock,
   input  qmci_pkg::qmci_load_type         load,
   input  logic [qmci_pkg::LEVEL_W-1:0]    level,
   input  logic [qmci_pkg::MORTON_W-1:0]   space,
   input  logic [qmci_pkg::LEVEL_W-1:0]    depth,
   input  logic                            ok,
   output logic [qmci_pkg::INDEX_W-1:0]    cell_index,
   output logic [qmci_pkg::DEPTH_W-1:0]    cell_depth,
   output logic                            invalid
);
   import qmci_pkg::*;

   logic [SUM_W-1:0]   sum;
   logic [SUM_W-1:0]   cells;
   logic               bad;
   logic [INDEX_W-1:0] index_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic               invalid_ff;

   assign sum   = SUM_W'(space) + level_offset({1'b0, depth});
   assign cells = level_offset({1'b0, level} + (LEVEL_W+1)'(1));
   assign bad   = !ok || (sum >= cells);

   always_ff @(posedge clock) begin
      if (load.s5) begin
         index_ff   <= bad ? '0 : INDEX_W'(sum);
         depth_ff   <= bad ? '0 : DEPTH_W'(depth);
         invalid_ff <= bad;
      end
   end

   assign cell_index = index_ff;
   assign cell_depth = depth_ff;
   assign invalid    = invalid_ff;

endmodule

### rtl/quadtree_morton_cell_index.sv
// Top level of the linear quadtree Morton cell index pipeline.
//
// A request carries one box (left, top, right, bottom, signed Q16.16). Each
// request yields one response with the linear quadtree cell index, the cell
// depth and an invalid flag for boxes that do not fit inside the grid.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. The pipeline has five register stages: origin subtract,
// reciprocal multiply (one 32 by 32 multiplier per corner), range check and
// Morton interleave, level search, and index offset with the result register.
// One request is taken every cycle while req_stall is low.
// When the receiver stalls, the result holds and empty stages still fill;
// req_stall rises only once every stage holds an item.
// Configuration writes on the csr_ channel are always ready and must only be
// made while the pipeline is empty. Reset empties the pipeline and loads the
// register defaults: level 3, region origin 0, reciprocal cell sizes 1.0.
module quadtree_morton_cell_index (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [qmci_pkg::FIX_W-1:0]  req_box_left,
   input  logic signed [qmci_pkg::FIX_W-1:0]  req_box_top,
   input  logic signed [qmci_pkg::FIX_W-1:0]  req_box_right,
   input  logic signed [qmci_pkg::FIX_W-1:0]  req_box_bottom,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [qmci_pkg::INDEX_W-1:0]       rsp_cell_index,
   output logic [qmci_pkg::DEPTH_W-1:0]       rsp_cell_depth,
   output logic                               rsp_invalid,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [qmci_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [qmci_pkg::FIX_W-1:0]         csr_data
);
   import qmci_pkg::*;

   logic [LEVEL_W-1:0]  tree_level_ff;
   logic [FIX_W-1:0]    region_left_ff;
   logic [FIX_W-1:0]    region_top_ff;
   logic [FIX_W-1:0]    inv_cell_width_ff;
   logic [FIX_W-1:0]    inv_cell_height_ff;
   logic [LEVEL_W-1:0]  level;

   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   qmci_load_type       load;

   logic [FIX_W-1:0]    left_grid, top_grid, right_grid, bottom_grid;
   logic [3:0]          neg;
   logic [MORTON_W-1:0] space;
   logic [LEVEL_W-1:0]  depth;
   logic                ok;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tree_level_ff      <= LEVEL_W'(3);
         region_left_ff     <= '0;
         region_top_ff      <= '0;
         inv_cell_width_ff  <= FIX_W'(65536);
         inv_cell_height_ff <= FIX_W'(65536);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TREE_LEVEL: begin
               tree_level_ff <= csr_data[LEVEL_W-1:0];
            end
            CSR_REGION_LEFT: begin
               region_left_ff <= csr_data;
            end
            CSR_REGION_TOP: begin
               region_top_ff <= csr_data;
            end
            CSR_INV_CELL_WIDTH: begin
               inv_cell_width_ff <= csr_data;
            end
            CSR_INV_CELL_HEIGHT: begin
               inv_cell_height_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign level = sat_level(tree_level_ff);

   always_comb begin
      load.s5 = !v5_ff || !rsp_stall;
      load.s4 = !v4_ff || load.s5;
      load.s3 = !v3_ff || load.s4;
      load.s2 = !v2_ff || load.s3;
      load.s1 = !v1_ff || load.s2;
   end

   assign req_stall = !load.s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (load.s1) v1_ff <= req_valid;
         if (load.s2) v2_ff <= v1_ff;
         if (load.s3) v3_ff <= v2_ff;
         if (load.s4) v4_ff <= v3_ff;
         if (load.s5) v5_ff <= v4_ff;
      end
   end

   qmci_corner u_left (
      .clock  (clock),
      .load   (load),
      .pos    (req_box_left),
      .origin (region_left_ff),
      .inv    (inv_cell_width_ff),
      .grid   (left_grid),
      .neg    (neg[0])
   );

   qmci_corner u_top (
      .clock  (clock),
      .load   (load),
      .pos    (req_box_top),
      .origin (region_top_ff),
      .inv    (inv_cell_height_ff),
      .grid   (top_grid),
      .neg    (neg[1])
   );

   qmci_corner u_right (
      .clock  (clock),
      .load   (load),
      .pos    (req_box_right),
      .origin (region_left_ff),
      .inv    (inv_cell_width_ff),
      .grid   (right_grid),
      .neg    (neg[2])
   );

   qmci_corner u_bottom (
      .clock  (clock),
      .load   (load),
      .pos    (req_box_bottom),
      .origin (region_top_ff),
      .inv    (inv_cell_height_ff),
      .grid   (bottom_grid),
      .neg    (neg[3])
   );

   qmci_encode u_encode (
      .clock       (clock),
      .load        (load),
      .level       (level),
      .left_grid   (left_grid),
      .top_grid    (top_grid),
      .right_grid  (right_grid),
      .bottom_grid (bottom_grid),
      .neg         (neg),
      .space       (space),
      .depth       (depth),
      .ok          (ok)
   );

   qmci_index u_index (
      .clock      (clock),
      .load       (load),
      .level      (level),
      .space      (space),
      .depth      (depth),
      .ok         (ok),
      .cell_index (rsp_cell_index),
      .cell_depth (rsp_cell_depth),
      .invalid    (rsp_invalid)
   );

   assign rsp_valid = v5_ff;

`ifndef ASSERT_OFF
   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> (rsp_cell_index == '0 && rsp_cell_depth == '0))
      else $error("invalid response carries a nonzero index or depth");

   a_depth_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_invalid) |-> (rsp_cell_depth <= DEPTH_W'(level)))
      else $error("cell depth exceeds the configured tree level");

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted request did not enter the first stage");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (req_stall) |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && rsp_stall))
      else $error("request stalled while the pipeline has room");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule
